// ----- design/text_console_writer_assert.svh -----
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// clocked check, off while reset is held
`define TCW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// check that applies to a result beat on offer
`define TCW_ASSERT_OUT(label, prop, msg) \
  `TCW_ASSERT(label, out_valid |-> (prop), msg)

`endif

// ----- design/tcw_pkg.sv -----
package tcw_pkg;

  // screen geometry
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;

  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int ADDR_W = $clog2(CELLS);
  localparam int CW1    = COL_W + 1;
  localparam int RW1    = ROW_W + 1;

  // port field widths
  localparam int FUNC_W = 2;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int TCOL_W = 7;
  localparam int TROW_W = 5;
  localparam int OCOL_W = 7;
  localparam int OROW_W = 5;
  localparam int POS_W  = 11;
  localparam int CELL_W = 16;

  // queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // function codes
  localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_MOVE  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd3;

  // character codes
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_BLANK     = 8'h20;

  localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;
  localparam int                TAB_STEP   = 8;

  // sweep bounds
  localparam logic [ADDR_W-1:0] LAST_CELL   = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] SCROLL_LAST = ADDR_W'((ROWS - 1) * COLUMNS - 1);
  localparam logic [ADDR_W-1:0] FILL_FIRST  = ADDR_W'((ROWS - 1) * COLUMNS);

  typedef enum logic [2:0] {
    OP_PRINT,
    OP_NEWLINE,
    OP_RETURN,
    OP_TAB,
    OP_BACKSPACE,
    OP_MOVE,
    OP_CLEAR,
    OP_READ
  } op_kind_t;

  typedef struct packed {
    op_kind_t                kind;
    logic [CHAR_W-1:0]       ch;
    logic [COL_W-1:0]        col;
    logic [ROW_W-1:0]        row;
    logic                    in_range;
  } op_t;

  typedef struct packed {
    logic valid;
    op_t  op;
  } q_head_t;

  typedef struct packed {
    logic space;
    logic init_busy;
  } accept_ctl_t;

  typedef struct packed {
    logic [OCOL_W-1:0] col;
    logic [OROW_W-1:0] row;
    logic [POS_W-1:0]  pos;
    logic [CELL_W-1:0] entry;
    logic              accepted;
  } res_t;

  function automatic logic [CELL_W-1:0] make_cell(input logic [ATTR_W-1:0] attr,
                                                   input logic [CHAR_W-1:0] ch);
    return {attr, ch};
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col);
    return ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);
  endfunction

  function automatic res_t make_result(input logic [COL_W-1:0]  col,
                                       input logic [ROW_W-1:0]  row,
                                       input logic [CELL_W-1:0] entry,
                                       input logic              acc);
    res_t r;
    r.col      = OCOL_W'(col);
    r.row      = OROW_W'(row);
    r.pos      = POS_W'(cell_addr(row, col));
    r.entry    = entry;
    r.accepted = acc;
    return r;
  endfunction

endpackage

// ----- design/tcw_front.sv -----
module tcw_front (
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [tcw_pkg::FUNC_W-1:0]  in_func,
  input  logic [tcw_pkg::CHAR_W-1:0]  in_char_code,
  input  logic [tcw_pkg::TCOL_W-1:0]  in_target_col,
  input  logic [tcw_pkg::TROW_W-1:0]  in_target_row,
  input  tcw_pkg::accept_ctl_t        ctl,
  output logic                        push,
  output tcw_pkg::op_t                op
);
  import tcw_pkg::*;

  always_comb begin
    in_ready = ctl.space && !ctl.init_busy;
    push     = in_valid && in_ready;

    op.ch       = in_char_code;
    op.col      = COL_W'(in_target_col);
    op.row      = ROW_W'(in_target_row);
    op.in_range = (32'(in_target_col) < COLUMNS) && (32'(in_target_row) < ROWS);

    unique case (in_func)
      FUNC_PUT: begin
        unique case (in_char_code)
          CH_NEWLINE:   op.kind = OP_NEWLINE;
          CH_RETURN:    op.kind = OP_RETURN;
          CH_TAB:       op.kind = OP_TAB;
          CH_BACKSPACE: op.kind = OP_BACKSPACE;
          default:      op.kind = OP_PRINT;
        endcase
      end
      FUNC_MOVE:  op.kind = OP_MOVE;
      FUNC_CLEAR: op.kind = OP_CLEAR;
      FUNC_READ:  op.kind = OP_READ;
      default:    op.kind = OP_READ;
    endcase
  end

endmodule

// ----- design/tcw_queue.sv -----
module tcw_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  tcw_pkg::op_t         op_in,
  input  logic                 pop,
  output tcw_pkg::q_head_t     head,
  output logic                 space
);
  import tcw_pkg::*;

  op_t               slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    space      = count_r != QCNT_W'(QDEPTH);
    head.valid = count_r != '0;
    head.op    = slot_r[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= op_in;
  end

endmodule

// ----- design/tcw_back.sv -----
module tcw_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [tcw_pkg::ATTR_W-1:0]  attr,
  input  tcw_pkg::q_head_t            head,
  output logic                        pop,
  output logic                        init_busy,
  output logic                        out_valid,
  input  logic                        out_ready,
  output tcw_pkg::res_t               res
);
  import tcw_pkg::*;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_READ,
    S_SCROLL,
    S_DRAIN,
    S_FILL
  } state_t;

  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] scan_r, scan_nxt;
  logic              wb_pend_r, wb_pend_nxt;
  logic [ADDR_W-1:0] wb_addr_r, wb_addr_nxt;
  logic [COL_W-1:0]  cur_col_r, cur_col_nxt;
  logic [ROW_W-1:0]  cur_row_r, cur_row_nxt;
  logic              out_valid_r, out_valid_nxt;
  res_t              res_r, res_nxt;

  logic [CELL_W-1:0] mem [CELLS];
  logic [CELL_W-1:0] rd_data_r;
  logic [ADDR_W-1:0] rd_addr;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [CELL_W-1:0] mem_wdata;

  logic              put_we;
  logic [ADDR_W-1:0] put_addr;
  logic [CELL_W-1:0] put_data;
  logic              slot_free;
  logic              is_put;
  logic [CW1-1:0]    col_w;
  logic [RW1-1:0]    row_w;

  always_comb begin
    state_nxt     = state_r;
    scan_nxt      = scan_r;
    wb_pend_nxt   = 1'b0;
    wb_addr_nxt   = wb_addr_r;
    cur_col_nxt   = cur_col_r;
    cur_row_nxt   = cur_row_r;
    out_valid_nxt = out_valid_r && !out_ready;
    res_nxt       = res_r;
    pop           = 1'b0;
    slot_free     = !out_valid_r || out_ready;
    put_we        = 1'b0;
    put_addr      = cell_addr(cur_row_r, cur_col_r);
    put_data      = make_cell(attr, head.op.ch);
    rd_addr       = scan_r + ADDR_W'(COLUMNS);
    is_put        = 1'b0;
    col_w         = {1'b0, cur_col_r};
    row_w         = {1'b0, cur_row_r};

    unique case (state_r)
      S_INIT: begin
        if (scan_r == LAST_CELL) begin
          state_nxt = S_IDLE;
          scan_nxt  = '0;
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end
      S_IDLE: begin
        rd_addr = cell_addr(head.op.row, head.op.col);
        if (head.valid && slot_free) begin
          pop = 1'b1;
          unique case (head.op.kind)
            OP_PRINT: begin
              is_put = 1'b1;
              put_we = 1'b1;
              col_w  = col_w + 1'b1;
            end
            OP_NEWLINE: begin
              is_put = 1'b1;
              col_w  = '0;
              row_w  = row_w + 1'b1;
            end
            OP_RETURN: begin
              is_put = 1'b1;
              col_w  = '0;
            end
            OP_TAB: begin
              is_put = 1'b1;
              col_w  = (col_w + CW1'(TAB_STEP)) & ~CW1'(TAB_STEP - 1);
            end
            OP_BACKSPACE: begin
              is_put   = 1'b1;
              put_we   = 1'b1;
              put_data = make_cell(attr, CH_BLANK);
              if (cur_col_r != '0) begin
                col_w = col_w - 1'b1;
              end else if (cur_row_r != '0) begin
                row_w = row_w - 1'b1;
                col_w = CW1'(COLUMNS - 1);
              end
              put_addr = cell_addr(ROW_W'(row_w), COL_W'(col_w));
            end
            OP_MOVE: begin
              if (head.op.in_range) begin
                cur_col_nxt = head.op.col;
                cur_row_nxt = head.op.row;
              end
              out_valid_nxt = 1'b1;
              res_nxt       = make_result(cur_col_nxt, cur_row_nxt, '0, head.op.in_range);
            end
            OP_CLEAR: begin
              cur_col_nxt = '0;
              cur_row_nxt = '0;
              scan_nxt    = '0;
              state_nxt   = S_FILL;
            end
            OP_READ: begin
              if (head.op.in_range) begin
                state_nxt = S_READ;
              end else begin
                out_valid_nxt = 1'b1;
                res_nxt       = make_result(cur_col_r, cur_row_r, '0, 1'b0);
              end
            end
            default: ;
          endcase

          if (is_put) begin
            // line wrap, then scroll off the bottom
            if (col_w >= CW1'(COLUMNS)) begin
              col_w = '0;
              row_w = row_w + 1'b1;
            end
            cur_col_nxt = COL_W'(col_w);
            if (row_w >= RW1'(ROWS)) begin
              cur_row_nxt = ROW_W'(ROWS - 1);
              scan_nxt    = '0;
              state_nxt   = S_SCROLL;
            end else begin
              cur_row_nxt   = ROW_W'(row_w);
              out_valid_nxt = 1'b1;
              res_nxt       = make_result(cur_col_nxt, cur_row_nxt, '0, 1'b1);
            end
          end
        end
      end
      S_READ: begin
        out_valid_nxt = 1'b1;
        res_nxt       = make_result(cur_col_r, cur_row_r, rd_data_r, 1'b1);
        state_nxt     = S_IDLE;
      end
      S_SCROLL: begin
        wb_pend_nxt = 1'b1;
        wb_addr_nxt = scan_r;
        if (scan_r == SCROLL_LAST) begin
          scan_nxt  = FILL_FIRST;
          state_nxt = S_DRAIN;
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end
      S_DRAIN: begin
        state_nxt = S_FILL;
      end
      S_FILL: begin
        if (scan_r == LAST_CELL) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          res_nxt       = make_result(cur_col_r, cur_row_r, '0, 1'b1);
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // single write port: pending copy, sweep fill, then character writes
  always_comb begin
    if (wb_pend_r) begin
      mem_we    = 1'b1;
      mem_waddr = wb_addr_r;
      mem_wdata = rd_data_r;
    end else if (state_r == S_INIT) begin
      mem_we    = 1'b1;
      mem_waddr = scan_r;
      mem_wdata = make_cell(RESET_ATTR, CH_BLANK);
    end else if (state_r == S_FILL) begin
      mem_we    = 1'b1;
      mem_waddr = scan_r;
      mem_wdata = make_cell(attr, CH_BLANK);
    end else begin
      mem_we    = put_we;
      mem_waddr = put_addr;
      mem_wdata = put_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      scan_r      <= '0;
      wb_pend_r   <= 1'b0;
      wb_addr_r   <= '0;
      cur_col_r   <= '0;
      cur_row_r   <= '0;
      out_valid_r <= 1'b0;
      res_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      scan_r      <= scan_nxt;
      wb_pend_r   <= wb_pend_nxt;
      wb_addr_r   <= wb_addr_nxt;
      cur_col_r   <= cur_col_nxt;
      cur_row_r   <= cur_row_nxt;
      out_valid_r <= out_valid_nxt;
      res_r       <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_data_r <= mem[rd_addr];
  end

  assign init_busy = state_r == S_INIT;
  assign out_valid = out_valid_r;
  assign res       = res_r;

endmodule

// ----- design/text_console_writer.sv -----
// a put, move or rejected read goes from the queue head to the result register; an
//   in-range read first passes the read state; a scroll or clear sweeps the cells
//   through the single write port of the screen memory, then registers its result
// throughput: one beat a cycle for simple operations, queue primed, out_ready high
// reset: synchronous active-low; afterwards a clearing pass writes all COLUMNS*ROWS
//   cells with in_ready low; config writes are taken throughout
module text_console_writer (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [tcw_pkg::ATTR_W-1:0]  cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [tcw_pkg::FUNC_W-1:0]  in_func,
  input  logic [tcw_pkg::CHAR_W-1:0]  in_char_code,
  input  logic [tcw_pkg::TCOL_W-1:0]  in_target_col,
  input  logic [tcw_pkg::TROW_W-1:0]  in_target_row,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [tcw_pkg::OCOL_W-1:0]  out_cursor_col,
  output logic [tcw_pkg::OROW_W-1:0]  out_cursor_row,
  output logic [tcw_pkg::POS_W-1:0]   out_cursor_position,
  output logic [tcw_pkg::CELL_W-1:0]  out_cell_entry,
  output logic                        out_accepted
);
  import tcw_pkg::*;

  // current text attribute, used for printed, blanked and cleared cells
  logic [ATTR_W-1:0] attr_r;

  accept_ctl_t ctl;
  logic        q_push;
  op_t         q_op;
  logic        q_pop;
  q_head_t     q_head;
  logic        q_space;
  logic        init_busy;
  res_t        res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= RESET_ATTR;
    end else if (cfg_we) begin
      attr_r <= cfg_wdata;
    end
  end

  // front: takes the input beat and decodes it into an operation
  tcw_front u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_func       (in_func),
    .in_char_code  (in_char_code),
    .in_target_col (in_target_col),
    .in_target_row (in_target_row),
    .ctl           (ctl),
    .push          (q_push),
    .op            (q_op)
  );

  assign ctl.space     = q_space;
  assign ctl.init_busy = init_busy;

  // short queue so the front keeps taking beats while the back is busy
  tcw_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .op_in (q_op),
    .pop   (q_pop),
    .head  (q_head),
    .space (q_space)
  );

  // back: owns the screen memory, cursor, scroll/clear sweeps and result register
  tcw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .attr      (attr_r),
    .head      (q_head),
    .pop       (q_pop),
    .init_busy (init_busy),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res       (res)
  );

  assign out_cursor_col      = res.col;
  assign out_cursor_row      = res.row;
  assign out_cursor_position = res.pos;
  assign out_cell_entry      = res.entry;
  assign out_accepted        = res.accepted;

  `include "text_console_writer_assert.svh"

  // the back never takes an operation the queue does not hold
  `TCW_ASSERT(a_pop_has_head, q_pop |-> q_head.valid, "pop from empty queue")
  // a rejected beat carries no cell contents
  `TCW_ASSERT_OUT(a_reject_no_cell, out_accepted || (out_cell_entry == '0), "cell on reject")
  // reported cursor stays on the screen
  `TCW_ASSERT_OUT(a_row_on_screen, 32'(out_cursor_row) < ROWS, "cursor row off screen")

endmodule
